@@ rtl/core/hswp_pkg.sv @@
`timescale 1ns / 1ps

package hswp_pkg;

  localparam int MAX_TYPES  = 7;
  localparam int SEED_W     = 32;
  localparam int WEIGHT_W   = 10;
  localparam int IDX_W      = 3;
  // max total is 7 * 1023, fits 13 bits
  localparam int SUM_W      = 13;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = WEIGHT_W;
  localparam int DIV_STEPS  = SEED_W;
  localparam int CNT_W      = $clog2(DIV_STEPS);

  localparam logic [SEED_W-1:0] HASH_MUL   = 32'h045d_9f3b;
  localparam logic [SEED_W-1:0] HASH_ADD   = 32'd1013904223;
  localparam int                HASH_SHIFT = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_COUNT  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_BASE = 4'd1;

  localparam logic [IDX_W-1:0] TYPE_COUNT_RESET = 3'd7;

  typedef logic [WEIGHT_W-1:0] weight_t;

  // status from the serial remainder unit
  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] rem;
  } rem_stat_t;

  function automatic weight_t weight_reset(input int i);
    weight_t w;
    case (i)
      0:       w = 10'd1;
      1:       w = 10'd2;
      2:       w = 10'd4;
      3:       w = 10'd8;
      4:       w = 10'd15;
      5:       w = 10'd25;
      6:       w = 10'd45;
      default: w = 10'd1;
    endcase
    return w;
  endfunction

endpackage

@@ rtl/core/hswp_rem.sv @@
`timescale 1ns / 1ps

module hswp_rem import hswp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SEED_W-1:0] dividend_i,
  input  logic [SUM_W-1:0]  divisor_i,
  output rem_stat_t         stat_o
);

  logic [SEED_W-1:0] shift_q, shift_d;
  logic [SUM_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [SUM_W:0]    trial;

  // one dividend bit per cycle, MSB first; rem stays below a nonzero divisor
  assign trial = {rem_q, shift_q[SEED_W-1]};

  always_comb begin
    shift_d = shift_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      shift_d = dividend_i;
      rem_d   = '0;
      cnt_d   = '0;
      busy_d  = 1'b1;
    end else if (busy_q) begin
      shift_d = {shift_q[SEED_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = SUM_W'(trial - {1'b0, divisor_i});
      end else begin
        rem_d = trial[SUM_W-1:0];
      end
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    rem_q   <= rem_d;
  end

  assign stat_o.done = done_q;
  assign stat_o.rem  = rem_q;

endmodule

@@ rtl/core/hashed_seed_weighted_pick.sv @@
`timescale 1ns / 1ps

// Weighted pick driven by a hashed seed. A seed request is mixed
// combinationally (xor-shift, one 32x32 multiply, add). A bit-serial
// remainder unit then reduces it modulo the sum of the active weights. That
// unit takes one seed bit per cycle and registers the remainder with a done
// flag. A last step finds the first entry whose running weight sum exceeds
// the remainder. One seed is in work at a time and a new seed is taken the
// cycle after the result is registered. The result sits in an output
// register, so a new seed is taken while an old result waits. Configuration
// writes are always ready; write them only while no pick is in flight.
module hashed_seed_weighted_pick import hswp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [SEED_W-1:0]     seed_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  found_o,
  output logic [IDX_W-1:0]      entry_index_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HASH,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e            state_q;
  logic [SEED_W-1:0] seed_q;
  logic [IDX_W-1:0]  type_count_q;
  weight_t           weights_q [MAX_TYPES];
  logic [SUM_W-1:0]  total_q;
  logic              out_valid_q;
  logic              found_q;
  logic [IDX_W-1:0]  index_q;

  logic [IDX_W-1:0]  n_act;
  logic [SUM_W-1:0]  cum [MAX_TYPES];
  logic [SEED_W-1:0] xs, mixed;
  logic              rem_start;
  rem_stat_t         rem_stat;
  logic              hit;
  logic [IDX_W-1:0]  hit_idx;
  logic              out_free;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);

  assign n_act = (type_count_q > IDX_W'(MAX_TYPES)) ? IDX_W'(MAX_TYPES) : type_count_q;

  // running sums, inactive entries masked to zero
  always_comb begin
    logic [SUM_W-1:0] acc;
    acc = '0;
    for (int i = 0; i < MAX_TYPES; i++) begin
      acc    = acc + ((IDX_W'(i) < n_act) ? SUM_W'(weights_q[i]) : '0);
      cum[i] = acc;
    end
  end

  assign xs        = seed_q ^ (seed_q >> HASH_SHIFT);
  assign mixed     = xs * HASH_MUL + HASH_ADD;
  assign rem_start = (state_q == ST_HASH);

  hswp_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (mixed),
    .divisor_i  (total_q),
    .stat_o     (rem_stat)
  );

  // first entry whose running sum exceeds the remainder
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < MAX_TYPES; i++) begin
      if (!hit && (IDX_W'(i) < n_act) && (rem_stat.rem < cum[i])) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      type_count_q <= TYPE_COUNT_RESET;
      for (int i = 0; i < MAX_TYPES; i++) begin
        weights_q[i] <= weight_reset(i);
      end
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_TYPE_COUNT) begin
          type_count_q <= cfg_data_i[IDX_W-1:0];
        end
        for (int i = 0; i < MAX_TYPES; i++) begin
          if (cfg_index_i == CFG_WEIGHT_BASE + CFG_IDX_W'(i)) begin
            weights_q[i] <= cfg_data_i;
          end
        end
      end

      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_HASH;
          end
        end
        ST_HASH: begin
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (rem_stat.done) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      seed_q <= seed_i;
    end
    if (state_q == ST_HASH) begin
      total_q <= cum[MAX_TYPES-1];
    end
    if (state_q == ST_DONE && out_free) begin
      // zero total leaves hit low, so nothing is found
      found_q <= hit;
      index_q <= hit ? hit_idx : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign entry_index_o = index_q;

endmodule

@@ rtl/core/hswp_checker.sv @@
`timescale 1ns / 1ps

module hswp_checker import hswp_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic                  found_o,
  input logic [IDX_W-1:0]      entry_index_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(found_o) && $stable(entry_index_o))
    else $error("result changed while stalled");

  // not-found results carry index zero
  a_notfound_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> entry_index_o == '0)
    else $error("nonzero index without a pick");

  // picked index lies among the entries
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> entry_index_o < IDX_W'(MAX_TYPES))
    else $error("picked index out of range");

  // one seed in work at a time: after a request the input closes
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o ##1 !in_ready_o)
    else $error("input reopened during a pick");

endmodule

bind hashed_seed_weighted_pick hswp_checker u_hswp_checker (.*);

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import hswp_pkg::*;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
  } pick_t;

  typedef logic [MAX_TYPES-1:0][WEIGHT_W-1:0] wheel_t;

  localparam int RANDOM_PHASES = 7;
  localparam int PHASE_PICKS   = 225;
  localparam int DRAIN_CYCLES  = 40;
  localparam int MAX_IDLE      = 8;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [SEED_W-1:0]     seed_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic                  found_o;
  logic [IDX_W-1:0]      entry_index_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // shadow copy of the wheel registers
  logic [IDX_W-1:0] wheel_count = 3'd7;
  wheel_t           wheel_w = {10'd45, 10'd25, 10'd15, 10'd8, 10'd4, 10'd2, 10'd1};

  pick_t pending_picks[$];
  int    mismatch_count = 0;
  bit    fast_mode = 1'b0;

  hashed_seed_weighted_pick dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .seed_i        (seed_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .found_o       (found_o),
    .entry_index_o (entry_index_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic pick_t predict_pick(input logic [SEED_W-1:0] s);
    logic [SEED_W-1:0] h;
    int unsigned       n;
    int unsigned       total;
    int unsigned       cumul;
    int unsigned       slot;
    int                i;
    pick_t             p;
    p = '0;
    n = wheel_count;
    if (n > MAX_TYPES) n = MAX_TYPES;
    total = 0;
    for (i = 0; i < n; i++) total += wheel_w[i];
    if (n == 0 || total == 0) return p;
    h = s ^ (s >> HASH_SHIFT);
    h = h * HASH_MUL + HASH_ADD;
    slot = h % total;
    cumul = 0;
    for (i = 0; i < n; i++) begin
      cumul += wheel_w[i];
      if (slot < cumul) begin
        p.found = 1'b1;
        p.idx   = IDX_W'(i);
        return p;
      end
    end
    return p;
  endfunction

  // leaves in_valid_i high; the caller either sends again or drains in the same step
  task automatic send_seed(input logic [SEED_W-1:0] s);
    int gap;
    gap = fast_mode ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    seed_i     <= s;
    do @(posedge clk_i); while (!in_ready_o);
    pending_picks.insert(pending_picks.size(), predict_pick(s));
  endtask

  task automatic wait_idle();
    if (in_valid_i) in_valid_i <= 1'b0;
    while (pending_picks.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_TYPE_COUNT)
      wheel_count = data[IDX_W-1:0];
    else if (idx >= CFG_WEIGHT_BASE && idx < CFG_WEIGHT_BASE + MAX_TYPES)
      wheel_w[idx - CFG_WEIGHT_BASE] = data;
  endtask

  task automatic program_wheel(input logic [IDX_W-1:0] cnt, input wheel_t w);
    int i;
    wait_idle();
    write_reg(CFG_TYPE_COUNT, CFG_DATA_W'(cnt));
    for (i = 0; i < MAX_TYPES; i++) write_reg(CFG_IDX_W'(CFG_WEIGHT_BASE + i), w[i]);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [WEIGHT_W-1:0] draw_weight();
    int r;
    r = $urandom_range(0, 19);
    case (r)
      0:       return '0;
      1:       return '1;
      2:       return 10'd1000;
      3:       return 10'd1;
      default: return WEIGHT_W'($urandom_range(1, 1000));
    endcase
  endfunction

  function automatic logic [SEED_W-1:0] draw_seed();
    int r;
    r = $urandom_range(0, 15);
    case (r)
      0:       return '0;
      1:       return '1;
      2:       return {16'h0, 16'($urandom)};
      3:       return {16'($urandom), 16'h0};
      default: return $urandom;
    endcase
  endfunction

  task automatic test_reset_wheel();
    send_seed(32'h0000_0000);
    send_seed(32'hffff_ffff);
    send_seed(32'h0000_ffff);
    send_seed(32'hffff_0000);
    send_seed(32'h8000_0000);
    send_seed(32'h0000_0001);
  endtask

  task automatic test_wheel_corners();
    // no active entries
    program_wheel(3'd0, {MAX_TYPES{10'd1000}});
    send_seed(32'h1234_5678);
    send_seed(32'hffff_ffff);
    // single entry of weight one
    program_wheel(3'd1, {MAX_TYPES{10'd1}});
    send_seed(32'h0000_0000);
    send_seed(32'hdead_beef);
    // every weight bit set
    program_wheel(3'd7, {MAX_TYPES{10'h3ff}});
    send_seed(32'h0000_0000);
    send_seed(32'hffff_ffff);
    send_seed(32'h5555_aaaa);
    // zero weights never win
    program_wheel(3'd7, {10'd0, 10'd7, 10'd500, 10'd0, 10'd3, 10'd1, 10'd0});
    send_seed(32'h0f0f_0f0f);
    send_seed(32'hf0f0_f0f0);
    send_seed(32'h0001_0000);
    // active weights all zero, later ones ignored
    program_wheel(3'd3, {10'd9, 10'd9, 10'd9, 10'd9, 10'd0, 10'd0, 10'd0});
    send_seed(32'h0000_0000);
    send_seed(32'hcafe_f00d);
    program_wheel(3'd7, {MAX_TYPES{10'd1000}});
    send_seed(32'h7fff_ffff);
    send_seed(32'h8000_0001);
  endtask

  task automatic test_unused_index();
    int k;
    wait_idle();
    for (k = CFG_WEIGHT_BASE + MAX_TYPES; k < 2 ** CFG_IDX_W; k++)
      write_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom));
    cfg_valid_i <= 1'b0;
    send_seed(32'h0000_0000);
    send_seed($urandom);
  endtask

  task automatic test_random_picks();
    wheel_t w;
    int     phase;
    int     n;
    int     i;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      for (i = 0; i < MAX_TYPES; i++) w[i] = draw_weight();
      n = $urandom_range(0, 9);
      if (n > MAX_TYPES) n = MAX_TYPES;
      program_wheel(IDX_W'(n), w);
      fast_mode = ($urandom_range(0, 3) == 0);
      for (i = 0; i < PHASE_PICKS; i++) begin
        // hold the sender until the block has fully drained
        if (i == PHASE_PICKS / 2) wait_idle();
        send_seed(draw_seed());
      end
    end
    fast_mode = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_wheel();
    test_wheel_corners();
    test_unused_index();
    test_random_picks();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // result side: random stall before each result, none in fast stretches
  initial begin
    int stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = fast_mode ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    pick_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_picks.size() == 0) begin
        $error("result with no pick pending: found %0d entry_index %0d",
               found_o, entry_index_o);
        mismatch_count++;
      end else begin
        want = pending_picks.pop_front();
        if (found_o !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, found_o);
          mismatch_count++;
        end
        if (entry_index_o !== want.idx) begin
          $error("entry_index: expected %0d, got %0d", want.idx, entry_index_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/hswp_pkg.sv
rtl/core/hswp_rem.sv
rtl/core/hashed_seed_weighted_pick.sv
rtl/core/hswp_checker.sv
dv/tb.sv
